FILE: hdl/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define DRHM_ASSERT_IMPL(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("drhm assertion failed");

// next-cycle implication, quiet while reset is held
`define DRHM_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("drhm assertion failed");

// next-cycle implication that also holds across reset
`define DRHM_ASSERT_NEXT_ALL(lbl, ant, con) \
  lbl: assert property (@(posedge clk) (ant) |=> (con)) \
    else $error("drhm assertion failed");

`endif

FILE: hdl/drhm_pkg.sv
`default_nettype none

package drhm_pkg;

  // map geometry
  localparam int MAP_WIDTH  = 256;
  localparam int MAP_HEIGHT = 256;
  localparam int COL_W      = (MAP_WIDTH > 1) ? $clog2(MAP_WIDTH) : 1;
  localparam int ROW_W      = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;
  localparam int MAP_DEPTH  = MAP_WIDTH * MAP_HEIGHT;
  localparam int ADDR_W     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  // pixel and factor formats
  localparam int PIX_W       = 20;
  localparam int FACTOR_W    = 16;
  localparam int KEEP_W      = FACTOR_W + 1;
  localparam int PROD_W      = PIX_W + KEEP_W;
  localparam logic [PIX_W-1:0]    PIX_MAX      = '1;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd6554;

  // stream field layout
  localparam int MODE_W     = 2;
  localparam int RCOL_W     = 11;
  localparam int RLEN_W     = 10;
  localparam int QRY_W      = 8;
  localparam int SPAN_W     = 13;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 24;

  localparam logic [MODE_W-1:0] MODE_DECAY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_DECAY,
    CMD_ADD,
    CMD_READ
  } cmd_kind_t;

  // decay and add carry an inclusive pixel window, read carries the pixel in col_lo/row_lo
  typedef struct packed {
    cmd_kind_t          kind;
    logic [COL_W-1:0]   col_lo;
    logic [COL_W-1:0]   col_hi;
    logic [ROW_W-1:0]   row_lo;
    logic [ROW_W-1:0]   row_hi;
    logic               in_map;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_stat_t;

endpackage

`default_nettype wire

FILE: hdl/drhm_ram.sv
`default_nettype none

module drhm_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hdl/drhm_front.sv
`default_nettype none

module drhm_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [drhm_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic [drhm_pkg::MODE_W-1:0]         in_tuser,
  input  wire logic                                q_full,
  input  wire drhm_pkg::back_stat_t                stat,
  output logic                                     push,
  output drhm_pkg::cmd_t                           entry
);

  import drhm_pkg::*;

  logic signed [RCOL_W-1:0] rect_col;
  logic signed [RCOL_W-1:0] rect_row;
  logic        [RLEN_W-1:0] rect_width;
  logic        [RLEN_W-1:0] rect_height;
  logic        [QRY_W-1:0]  query_col;
  logic        [QRY_W-1:0]  query_row;

  logic signed [SPAN_W-1:0] c_a, c_b, r_a, r_b, c_hi, r_hi;
  logic        [RLEN_W-1:0] qc_ext, qr_ext;
  logic                     c_ok, r_ok, wanted;

  assign rect_col    = in_tdata[10:0];
  assign rect_row    = in_tdata[21:11];
  assign rect_width  = in_tdata[31:22];
  assign rect_height = in_tdata[41:32];
  assign query_col   = in_tdata[49:42];
  assign query_row   = in_tdata[57:50];

  // clip [start, start+len) to the map
  always_comb begin
    c_a  = {{(SPAN_W-RCOL_W){rect_col[RCOL_W-1]}}, rect_col};
    c_b  = c_a + {{(SPAN_W-RLEN_W){1'b0}}, rect_width};
    r_a  = {{(SPAN_W-RCOL_W){rect_row[RCOL_W-1]}}, rect_row};
    r_b  = r_a + {{(SPAN_W-RLEN_W){1'b0}}, rect_height};
    if (c_a < 0) c_a = '0;
    if (r_a < 0) r_a = '0;
    if (c_b > SPAN_W'(MAP_WIDTH))  c_b = SPAN_W'(MAP_WIDTH);
    if (r_b > SPAN_W'(MAP_HEIGHT)) r_b = SPAN_W'(MAP_HEIGHT);
    c_ok = c_a < c_b;
    r_ok = r_a < r_b;
    c_hi = c_b - SPAN_W'(1);
    r_hi = r_b - SPAN_W'(1);
  end

  assign qc_ext = {{(RLEN_W-QRY_W){1'b0}}, query_col};
  assign qr_ext = {{(RLEN_W-QRY_W){1'b0}}, query_row};

  always_comb begin
    entry  = '0;
    wanted = 1'b0;
    case (in_tuser)
      MODE_DECAY: begin
        wanted       = 1'b1;
        entry.kind   = CMD_DECAY;
        entry.col_lo = '0;
        entry.col_hi = COL_W'(MAP_WIDTH - 1);
        entry.row_lo = '0;
        entry.row_hi = ROW_W'(MAP_HEIGHT - 1);
      end
      MODE_ADD: begin
        wanted       = c_ok && r_ok;
        entry.kind   = CMD_ADD;
        entry.col_lo = c_a[COL_W-1:0];
        entry.col_hi = c_hi[COL_W-1:0];
        entry.row_lo = r_a[ROW_W-1:0];
        entry.row_hi = r_hi[ROW_W-1:0];
      end
      MODE_READ: begin
        wanted       = 1'b1;
        entry.kind   = CMD_READ;
        entry.col_lo = qc_ext[COL_W-1:0];
        entry.row_lo = qr_ext[ROW_W-1:0];
        entry.in_map = (qc_ext < RLEN_W'(MAP_WIDTH)) && (qr_ext < RLEN_W'(MAP_HEIGHT));
      end
      default: begin
        wanted = 1'b0;
      end
    endcase
  end

  // unused mode and empty rectangles are swallowed here
  assign in_tready = rst_n && !q_full && !stat.clearing;
  assign push      = in_tvalid && in_tready && wanted;

  logic unused_clk;
  assign unused_clk = clk & stat.busy;

endmodule

`default_nettype wire

FILE: hdl/drhm_queue.sv
`default_nettype none

module drhm_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire drhm_pkg::cmd_t entry,
  input  wire logic           pop,
  output drhm_pkg::cmd_t      head,
  output logic                empty,
  output logic                full
);

  import drhm_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= entry;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/drhm_back.sv
`default_nettype none

module drhm_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire drhm_pkg::cmd_t                q_head,
  input  wire logic                          q_empty,
  output logic                               q_pop,
  input  wire logic [drhm_pkg::FACTOR_W-1:0] factor,
  output drhm_pkg::back_stat_t               stat,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [drhm_pkg::PIX_W-1:0]         out_pixel
);

  import drhm_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_READ,
    ST_DRAIN
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_pix_r, out_pix_nxt;

  logic [ADDR_W-1:0] head_base, head_addr, run_addr, rd_addr;
  logic              ram_we;
  logic [PIX_W-1:0]  ram_wdata, rd_data;
  logic [KEEP_W-1:0] keep;
  logic [PROD_W-1:0] prod;
  logic [PIX_W:0]    sum;
  logic [PIX_W-1:0]  upd;
  logic              out_free, start;

  assign head_base = ADDR_W'(q_head.row_lo) * ADDR_W'(MAP_WIDTH);
  assign head_addr = head_base + ADDR_W'(q_head.col_lo);
  assign run_addr  = base_r + ADDR_W'(col_r);
  assign rd_addr   = (state_r == ST_RUN) ? run_addr : head_addr;

  assign out_free = !out_valid_r || out_ready;
  assign start    = (state_r == ST_IDLE) && !q_empty && ((q_head.kind != CMD_READ) || out_free);
  assign q_pop    = start;

  // read-modify-write datapath, read data is registered and comes back in the cycle after the read address
  assign keep = KEEP_W'(2 ** FACTOR_W) - {1'b0, factor};
  assign prod = {{KEEP_W{1'b0}}, rd_data} * {{PIX_W{1'b0}}, keep};
  assign sum  = {1'b0, rd_data} + {{(PIX_W+1-FACTOR_W){1'b0}}, factor};
  always_comb begin
    if (cmd_r.kind == CMD_DECAY) begin
      upd = prod[PIX_W+FACTOR_W-1:FACTOR_W];
    end else begin
      upd = sum[PIX_W] ? PIX_MAX : sum[PIX_W-1:0];
    end
  end

  assign ram_we    = (state_r == ST_CLEAR) || wr_pend_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : upd;

  drhm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (addr_r),
    .wr_data (ram_wdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    addr_nxt      = addr_r;
    wr_pend_nxt   = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_pix_nxt   = out_pix_r;
    case (state_r)
      ST_CLEAR: begin
        addr_nxt = addr_r + 1'b1;
        if (addr_r == ADDR_W'(MAP_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_nxt = q_head;
          if (q_head.kind == CMD_READ) begin
            if (q_head.in_map) begin
              state_nxt = ST_READ;
            end else begin
              out_valid_nxt = 1'b1;
              out_pix_nxt   = '0;
            end
          end else begin
            col_nxt   = q_head.col_lo;
            row_nxt   = q_head.row_lo;
            base_nxt  = head_base;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        wr_pend_nxt = 1'b1;
        addr_nxt    = run_addr;
        if (col_r == cmd_r.col_hi) begin
          col_nxt = cmd_r.col_lo;
          if (row_r == cmd_r.row_hi) begin
            state_nxt = ST_DRAIN;
          end else begin
            row_nxt  = row_r + 1'b1;
            base_nxt = base_r + ADDR_W'(MAP_WIDTH);
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_pix_nxt   = rd_data;
        state_nxt     = ST_IDLE;
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r     <= cmd_nxt;
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    base_r    <= base_nxt;
    out_pix_r <= out_pix_nxt;
  end

  assign stat.clearing = (state_r == ST_CLEAR);
  assign stat.busy     = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_pixel     = out_pix_r;

endmodule

`default_nettype wire

FILE: hdl/decaying_rectangle_heat_map.sv
// read result: an in-map read goes through ST_READ and the registered map read to the result register
// sweep: a decay visits the whole map and an add its clipped pixels, using the one read port and
//   one write port of the map memory; the back takes its next command only once the sweep is done
// reset: rst_n low for one clock; then a clearing pass over all MAP_WIDTH*MAP_HEIGHT pixels
//   zeroes the map with in_tready low; the blend factor returns to 6554 at once
`default_nettype none

module decaying_rectangle_heat_map (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input stream
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // rect_col[10:0] rect_row[21:11] rect_width[31:22] rect_height[41:32]
  // query_col[49:42] query_row[57:50], rest zero
  input  wire logic [drhm_pkg::IN_TDATA_W-1:0]      in_tdata,
  // mode[1:0]
  input  wire logic [drhm_pkg::MODE_W-1:0]          in_tuser,
  // result stream
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // pixel_value[19:0], rest zero
  output logic [drhm_pkg::OUT_TDATA_W-1:0]          out_tdata,
  // blend factor register
  input  wire logic                                 cfg_wr_en,
  input  wire logic [drhm_pkg::FACTOR_W-1:0]        cfg_wr_data
);

  import drhm_pkg::*;

  logic [FACTOR_W-1:0] factor_r, factor_nxt;

  // front to queue
  logic       push;
  cmd_t       entry;
  // queue to back
  cmd_t       q_head;
  logic       q_empty, q_full, q_pop;
  back_stat_t stat;
  logic [PIX_W-1:0] out_pixel;

  // blend factor; the user must write it only while nothing is in flight, the block does not enforce this
  assign factor_nxt = cfg_wr_en ? cfg_wr_data : factor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= FACTOR_RESET;
    end else begin
      factor_r <= factor_nxt;
    end
  end

  // front: takes transactions, clips rectangles, drops what has no effect
  drhm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .stat      (stat),
    .push      (push),
    .entry     (entry)
  );

  // short command queue lets the front keep taking transactions during a sweep
  drhm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .entry (entry),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty),
    .full  (q_full)
  );

  // back: sweeps the map memory one pixel a cycle and owns the result register
  drhm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .factor    (factor_r),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (out_pixel)
  );

  assign out_tdata = {{(OUT_TDATA_W-PIX_W){1'b0}}, out_pixel};

endmodule

`default_nettype wire

FILE: hdl/drhm_checker.sv
`default_nettype none
`include "assert_macros.svh"

module drhm_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [drhm_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  import drhm_pkg::*;

  // a stalled result holds its transaction
  `DRHM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // padding above the pixel stays zero
  `DRHM_ASSERT_IMPL(a_out_pad, out_tvalid, out_tdata[OUT_TDATA_W-1:PIX_W] == '0)

  // reset starts the clearing pass: no input taken and no result shown
  `DRHM_ASSERT_NEXT_ALL(a_rst_clear, !rst_n, !in_tready && !out_tvalid)

  logic unused_in_tvalid;
  assign unused_in_tvalid = in_tvalid;

endmodule

bind decaying_rectangle_heat_map drhm_checker u_drhm_checker (.*);

`default_nettype wire

FILE: dv/tb_decaying_rectangle_heat_map.sv
module tb_decaying_rectangle_heat_map;
  import drhm_pkg::*;

  // mode code the block leaves unused: such a transaction is dropped
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // rough ceiling: clearing pass, a handful of whole-map decays and one whole-map add,
  // each a sweep of the whole map, plus stalls; taken several times over
  localparam int LIMIT_CYCLES  = 4_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_MAX    = 10;

  // one input transaction: mode goes on tuser, the other fields are listed from the low end of tdata up
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [RCOL_W-1:0] rcol;
    logic signed [RCOL_W-1:0] rrow;
    logic [RLEN_W-1:0]        rw;
    logic [RLEN_W-1:0]        rh;
    logic [QRY_W-1:0]         qc;
    logic [QRY_W-1:0]         qr;
  } heat_cmd_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus side: the inputs are driven to known values from time zero
  logic                    in_tvalid   = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata    = '0;
  logic [MODE_W-1:0]       in_tuser    = '0;
  logic                    out_tvalid;
  logic                    out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    cfg_wr_en   = 1'b0;
  logic [FACTOR_W-1:0]     cfg_wr_data = '0;

  decaying_rectangle_heat_map dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // predicted state: our own copy of the map and of the blend factor
  logic [PIX_W-1:0]    heat_map_model [MAP_DEPTH];
  logic [FACTOR_W-1:0] factor_model = FACTOR_RESET;
  logic [PIX_W-1:0]    pixel_expect_q [$];

  int fail_count     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;

  // receiver hold-off: the stimulus bumps the request count, the receiver owns the countdown
  int hold_req_seq  = 0;
  int hold_seen_seq = 0;
  int hold_left     = 0;

  initial begin
    foreach (heat_map_model[i]) heat_map_model[i] = '0;
  end

  // ---------------------------------------------------------------- predictor

  // whole-map decay: v = v * (1 - f), truncated, product kept at full width
  function automatic void decay_map_model();
    logic [KEEP_W-1:0] keep;
    logic [PROD_W-1:0] prod;
    keep = 17'h10000 - {1'b0, factor_model};
    for (int i = 0; i < MAP_DEPTH; i++) begin
      prod = PROD_W'(heat_map_model[i]) * PROD_W'(keep);
      heat_map_model[i] = prod[FACTOR_W +: PIX_W];
    end
  endfunction

  // clip the signed rectangle to the map, then add f with saturation
  function automatic void add_rect_model(heat_cmd_t c);
    int c0, c1, r0, r1;
    int unsigned s;
    c0 = int'($signed(c.rcol));
    r0 = int'($signed(c.rrow));
    c1 = c0 + int'(c.rw);
    r1 = r0 + int'(c.rh);
    if (c0 < 0) c0 = 0;
    if (r0 < 0) r0 = 0;
    if (c1 > MAP_WIDTH) c1 = MAP_WIDTH;
    if (r1 > MAP_HEIGHT) r1 = MAP_HEIGHT;
    // empty after clipping: zero size or entirely off the map
    if (c0 >= c1 || r0 >= r1) return;
    for (int r = r0; r < r1; r++) begin
      for (int col = c0; col < c1; col++) begin
        s = heat_map_model[r * MAP_WIDTH + col] + factor_model;
        heat_map_model[r * MAP_WIDTH + col] = (s > PIX_MAX) ? PIX_MAX : PIX_W'(s);
      end
    end
  endfunction

  // apply one accepted transaction and queue the pixel a read should return
  function automatic void predict_cmd(heat_cmd_t c);
    logic [PIX_W-1:0] v;
    if (c.mode == MODE_DECAY) begin
      decay_map_model();
    end else if (c.mode == MODE_ADD) begin
      add_rect_model(c);
    end else if (c.mode == MODE_READ) begin
      v = '0;
      // off-map read still answers, with zero
      if (int'(c.qc) < MAP_WIDTH && int'(c.qr) < MAP_HEIGHT)
        v = heat_map_model[int'(c.qr) * MAP_WIDTH + int'(c.qc)];
      pixel_expect_q.push_back(v);
    end
  endfunction

  // ---------------------------------------------------------------- transaction builders

  function automatic heat_cmd_t decay_cmd();
    heat_cmd_t c;
    c = '0;
    c.mode = MODE_DECAY;
    return c;
  endfunction

  function automatic heat_cmd_t add_cmd(int col, int row, int w, int h);
    heat_cmd_t c;
    c = '0;
    c.mode = MODE_ADD;
    c.rcol = RCOL_W'(col);
    c.rrow = RCOL_W'(row);
    c.rw   = RLEN_W'(w);
    c.rh   = RLEN_W'(h);
    return c;
  endfunction

  function automatic heat_cmd_t read_cmd(int qcol, int qrow);
    heat_cmd_t c;
    c = '0;
    c.mode = MODE_READ;
    c.qc   = QRY_W'(qcol);
    c.qr   = QRY_W'(qrow);
    return c;
  endfunction

  // random transaction: fields not used by the mode carry noise too;
  // adds and reads mostly hit a small hot corner so values build up and get read back
  function automatic heat_cmd_t rand_cmd(bit allow_decay);
    heat_cmd_t c;
    int pick;
    c.rcol = RCOL_W'($urandom);
    c.rrow = RCOL_W'($urandom);
    c.rw   = RLEN_W'($urandom);
    c.rh   = RLEN_W'($urandom);
    c.qc   = QRY_W'($urandom);
    c.qr   = QRY_W'($urandom);
    pick = $urandom_range(0, 99);
    if (allow_decay && pick < 4) begin
      c.mode = MODE_DECAY;
    end else if (pick < 9) begin
      c.mode = MODE_UNUSED;
    end else if (pick < 54) begin
      c.mode = MODE_ADD;
      if ($urandom_range(0, 6) == 0) begin
        // long thin strip from anywhere, kept cheap by its short side
        if ($urandom_range(0, 1) == 0) begin
          c.rrow = RCOL_W'($urandom_range(0, 48)) - RCOL_W'(8);
          c.rh   = RLEN_W'($urandom_range(0, 6));
        end else begin
          c.rcol = RCOL_W'($urandom_range(0, 48)) - RCOL_W'(8);
          c.rw   = RLEN_W'($urandom_range(0, 6));
        end
      end else begin
        c.rcol = RCOL_W'($urandom_range(0, 48)) - RCOL_W'(8);
        c.rrow = RCOL_W'($urandom_range(0, 48)) - RCOL_W'(8);
        c.rw   = RLEN_W'($urandom_range(0, 12));
        c.rh   = RLEN_W'($urandom_range(0, 12));
      end
    end else begin
      c.mode = MODE_READ;
      if ($urandom_range(0, 3) != 0) begin
        c.qc = QRY_W'($urandom_range(0, 40));
        c.qr = QRY_W'($urandom_range(0, 40));
      end
    end
    return c;
  endfunction

  // ---------------------------------------------------------------- drivers

  // offer one transaction, with random sender gaps, and predict it once taken
  task automatic send_cmd(input heat_cmd_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tuser  = c.mode;
    in_tdata  = IN_TDATA_W'({c.qr, c.qc, c.rh, c.rw, c.rrow, c.rcol});
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_cmd(c);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_results_done();
    while (pixel_expect_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // reads are answered in order, so a read coming back means every earlier decay
  // and add has finished; a short pause on top covers the read's own tail
  task automatic settle_block();
    send_cmd(read_cmd(0, 0));
    wait_results_done();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_factor(input logic [FACTOR_W-1:0] f);
    settle_block();
    cfg_wr_data = f;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en    = 1'b0;
    factor_model = f;
  endtask

  // result side: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_req_seq != hold_seen_seq) begin
      hold_seen_seq = hold_req_seq;
      hold_left     = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- checking

  function automatic void note_failure(string what, logic [PIX_W-1:0] exp_v,
                                      logic [OUT_TDATA_W-1:0] got);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("%0d: %s pixel_value expected %0d got %0d", cycle_count, what, exp_v,
               got[PIX_W-1:0]);
  endfunction

  // every result transaction is matched against the oldest predicted pixel
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pixel_expect_q.size() == 0) begin
        note_failure("unexpected result,", '0, out_tdata);
      end else if (out_tdata[PIX_W-1:0] !== pixel_expect_q[0]) begin
        note_failure("mismatch,", pixel_expect_q[0], out_tdata);
        void'(pixel_expect_q.pop_front());
      end else begin
        void'(pixel_expect_q.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL decaying_rectangle_heat_map");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // map comes up cleared and the factor at its reset value
  task automatic test_after_reset();
    send_cmd(read_cmd(0, 0));
    send_cmd(read_cmd(255, 255));
    send_cmd(add_cmd(10, 20, 3, 2));
    send_cmd(read_cmd(11, 21));
    send_cmd(read_cmd(13, 21));
    send_cmd(decay_cmd());
    send_cmd(read_cmd(11, 21));
  endtask

  // rectangles that miss the map, get clipped, or have no size; unused mode dropped
  task automatic test_rect_clipping();
    heat_cmd_t c;
    send_cmd(add_cmd(-1024, -1024, 1023, 1023));
    send_cmd(add_cmd(5, 5, 0, 7));
    send_cmd(add_cmd(5, 5, 7, 0));
    send_cmd(add_cmd(1023, 1023, 1023, 1023));
    send_cmd(add_cmd(-3, 254, 5, 5));
    send_cmd(add_cmd(250, -2, 1023, 4));
    c = add_cmd(0, 0, 4, 4);
    c.mode = MODE_UNUSED;
    send_cmd(c);
    send_cmd(read_cmd(0, 255));
    send_cmd(read_cmd(255, 1));
  endtask

  // one rectangle covering the whole map, the slowest add
  task automatic test_full_map();
    send_cmd(add_cmd(0, 0, 1023, 1023));
    send_cmd(read_cmd(128, 77));
  endtask

  // largest factor piles up in the clipped corner until it saturates, then decays to almost nothing;
  // zero factor leaves the map alone
  task automatic test_factor_extremes();
    write_factor(16'hFFFF);
    repeat (16) send_cmd(add_cmd(-3, 254, 5, 5));
    send_cmd(read_cmd(1, 254));
    send_cmd(decay_cmd());
    send_cmd(read_cmd(0, 255));
    write_factor(16'h0000);
    send_cmd(decay_cmd());
    send_cmd(add_cmd(0, 254, 2, 2));
    send_cmd(read_cmd(1, 255));
  endtask

  // long receiver hold-off while reads keep coming, so the command queue fills and
  // in_tready drops; then the sender waits for every result
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req_seq++;
    wait (hold_left > 0);
    for (int i = 0; i < 12; i++) begin
      if (i == 5)
        send_cmd(add_cmd(2, 2, 4, 4));
      else
        send_cmd(read_cmd($urandom_range(0, 40), $urandom_range(0, 40)));
    end
    wait_results_done();
  endtask

  // random transactions at one factor and one idling mix, at most one decay each
  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input logic [FACTOR_W-1:0] f);
    heat_cmd_t c;
    int counted;
    int decays;
    write_factor(f);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    counted = 0;
    decays  = 0;
    while (counted < PHASE_ITEMS) begin
      c = rand_cmd(decays == 0);
      send_cmd(c);
      if (c.mode == MODE_DECAY) decays++;
      if (c.mode != MODE_UNUSED) counted++;
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_after_reset();
    test_rect_clipping();
    test_full_map();
    test_factor_extremes();
    test_output_backpressure();
    test_random_phase(0, 0, FACTOR_W'($urandom_range(1, 65534)));
    test_random_phase(66, 0, 16'h8000);
    test_random_phase(0, 66, 16'hFFFF);
    test_random_phase(29, 29, FACTOR_W'($urandom_range(1, 65534)));
    settle_block();

    if (pixel_expect_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("PASS decaying_rectangle_heat_map");
    end else begin
      $display("FAIL decaying_rectangle_heat_map");
    end
    $finish;
  end

endmodule
